>>> sv/otsp_pkg.sv
// otsp_pkg: shared types and constants of the one-shot timer pool
// no dependencies; used by every module of the pool
`timescale 1ns / 1ps

package otsp_pkg;

    // command codes of an input transaction
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_STATUS = 2'd3;

    // event kinds of a result transaction
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_STOP    = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;
    localparam logic [1:0] KIND_EXPIRED = 2'd3;

    // expiry reports per tick
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int SLOT_ID_W = 3;

    // classified command as it travels through the queue
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] period;
        logic [3:0]  timer_select;
        logic        period_ok;
        logic        sel_ok;
    } t_cmd;

endpackage

>>> sv/otsp_front.sv
// otsp_front: accepts input transactions and classifies them for the back end
// depends on otsp_pkg
`timescale 1ns / 1ps

module otsp_front #(
    parameter int TIMER_SLOTS = 8
) (
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [31:0]        i_period,
    input  logic [3:0]         i_timer_select,
    input  logic               i_q_full,
    output logic               o_push,
    output otsp_pkg::t_cmd     o_entry
);

    logic [6:0] w_nib_sum;
    logic [4:0] w_fold;
    logic       w_mod5_zero;

    // 16 is 1 mod 5, so the nibble sum keeps the residue mod 5
    always_comb begin
        w_nib_sum = 7'd0;
        for (int k = 0; k < 8; k++) begin
            w_nib_sum = w_nib_sum + {3'd0, i_period[4*k +: 4]};
        end
        w_fold      = {2'd0, w_nib_sum[6:4]} + {1'b0, w_nib_sum[3:0]};
        w_mod5_zero = (w_fold == 5'd0) || (w_fold == 5'd5) || (w_fold == 5'd10) ||
                      (w_fold == 5'd15) || (w_fold == 5'd20);
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_entry.command      = i_command;
        o_entry.period       = i_period;
        o_entry.timer_select = i_timer_select;
        o_entry.period_ok    = !i_period[0] && w_mod5_zero;
        o_entry.sel_ok       = 32'(i_timer_select) < 32'(TIMER_SLOTS);
    end

endmodule

>>> sv/otsp_queue.sv
// otsp_queue: short command queue that decouples the front from the back end
// depends on otsp_pkg
`timescale 1ns / 1ps

module otsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  otsp_pkg::t_cmd  i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output otsp_pkg::t_cmd  o_head
);

    otsp_pkg::t_cmd                r_entry [otsp_pkg::QUEUE_DEPTH];
    logic [otsp_pkg::QP_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [otsp_pkg::QP_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [otsp_pkg::QC_W-1:0]     r_count, n_count;
    logic                          w_do_push, w_do_pop;

    assign o_full    = r_count == otsp_pkg::QC_W'(otsp_pkg::QUEUE_DEPTH);
    assign o_empty   = r_count == '0;
    assign o_head    = r_entry[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == otsp_pkg::QP_W'(otsp_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == otsp_pkg::QP_W'(otsp_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_entry[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> sv/otsp_back.sv
// otsp_back: sequencer that carries out commands over the slot store
// depends on otsp_pkg; holds the remaining-count memory and the output register
`timescale 1ns / 1ps

module otsp_back #(
    parameter int TIMER_SLOTS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  otsp_pkg::t_cmd  i_q_head,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [1:0]      o_event_kind,
    output logic [2:0]      o_slot_id,
    output logic            o_ok,
    output logic            o_was_running,
    output logic            o_slot_status,
    output logic            o_last
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TICK  = 2'd1;
    localparam logic [1:0] ST_START = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]                 r_state, n_state;
    otsp_pkg::t_cmd             r_cmd, n_cmd;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [otsp_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [TIMER_SLOTS-1:0]     r_running, n_running;

    logic       r_pend_valid, n_pend_valid;
    logic [1:0] r_pend_kind, n_pend_kind;
    logic [2:0] r_pend_id, n_pend_id;
    logic       r_pend_ok, n_pend_ok;
    logic       r_pend_was, n_pend_was;
    logic       r_pend_status, n_pend_status;

    logic       r_out_valid, n_out_valid;
    logic [1:0] r_out_kind, n_out_kind;
    logic [2:0] r_out_id, n_out_id;
    logic       r_out_ok, n_out_ok;
    logic       r_out_was, n_out_was;
    logic       r_out_status, n_out_status;
    logic       r_out_last, n_out_last;

    logic [31:0]      r_mem [TIMER_SLOTS];
    logic [31:0]      r_rd_data;
    logic             w_rd_en, w_wr_en;
    logic [IDX_W-1:0] w_rd_addr, w_wr_addr;
    logic [31:0]      w_wr_data;

    logic             w_out_free, w_stall, w_expire, w_last_slot, w_tick_emit;
    logic [31:0]      w_dec;
    logic [IDX_W-1:0] w_sel_idx, w_idx_inc;

    // low three bits of a slot index, zero-extended for small pools
    function automatic logic [2:0] SLOT_ID_CAST(input logic [IDX_W-1:0] idx);
        logic [IDX_W+2:0] wide;
        wide = {3'd0, idx};
        return wide[2:0];
    endfunction

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_dec       = r_rd_data - 32'd1;
    assign w_expire    = r_running[r_idx] && (w_dec == 32'd0);
    assign w_last_slot = r_idx == IDX_W'(TIMER_SLOTS - 1);
    assign w_idx_inc   = r_idx + 1'b1;
    assign w_sel_idx   = IDX_W'(i_q_head.timer_select);
    assign w_stall     = (r_state == ST_TICK) && w_expire &&
                         (r_cnt < otsp_pkg::CNT_W'(otsp_pkg::MAX_RESULTS)) &&
                         r_pend_valid && !w_out_free;
    assign w_tick_emit = (r_state == ST_TICK) && !w_stall && w_expire &&
                         (r_cnt < otsp_pkg::CNT_W'(otsp_pkg::MAX_RESULTS)) && r_pend_valid;

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_idx         = r_idx;
        n_cnt         = r_cnt;
        n_running     = r_running;
        n_pend_valid  = r_pend_valid;
        n_pend_kind   = r_pend_kind;
        n_pend_id     = r_pend_id;
        n_pend_ok     = r_pend_ok;
        n_pend_was    = r_pend_was;
        n_pend_status = r_pend_status;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_kind    = r_out_kind;
        n_out_id      = r_out_id;
        n_out_ok      = r_out_ok;
        n_out_was     = r_out_was;
        n_out_status  = r_out_status;
        n_out_last    = r_out_last;
        o_q_pop       = 1'b0;
        w_rd_en       = 1'b0;
        w_rd_addr     = r_idx;
        w_wr_en       = 1'b0;
        w_wr_addr     = r_idx;
        w_wr_data     = w_dec;

        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head;
                    case (i_q_head.command)
                        otsp_pkg::CMD_TICK: begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = '0;
                            n_idx     = '0;
                            n_cnt     = '0;
                            n_state   = ST_TICK;
                        end
                        otsp_pkg::CMD_START: begin
                            if (i_q_head.period_ok) begin
                                n_idx   = '0;
                                n_state = ST_START;
                            end else begin
                                n_pend_valid  = 1'b1;
                                n_pend_kind   = otsp_pkg::KIND_START;
                                n_pend_id     = 3'd0;
                                n_pend_ok     = 1'b0;
                                n_pend_was    = 1'b0;
                                n_pend_status = 1'b0;
                                n_state       = ST_FLUSH;
                            end
                        end
                        otsp_pkg::CMD_STOP: begin
                            n_pend_valid  = 1'b1;
                            n_pend_kind   = otsp_pkg::KIND_STOP;
                            n_pend_id     = i_q_head.timer_select[2:0];
                            n_pend_ok     = i_q_head.sel_ok;
                            n_pend_was    = i_q_head.sel_ok && r_running[w_sel_idx];
                            n_pend_status = 1'b0;
                            if (i_q_head.sel_ok) begin
                                n_running[w_sel_idx] = 1'b0;
                            end
                            n_state = ST_FLUSH;
                        end
                        default: begin
                            n_pend_valid  = 1'b1;
                            n_pend_kind   = otsp_pkg::KIND_STATUS;
                            n_pend_id     = i_q_head.timer_select[2:0];
                            n_pend_ok     = i_q_head.sel_ok;
                            n_pend_was    = 1'b0;
                            n_pend_status = i_q_head.sel_ok && r_running[w_sel_idx];
                            n_state       = ST_FLUSH;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (!w_stall) begin
                    if (r_running[r_idx]) begin
                        w_wr_en = 1'b1;
                    end
                    if (w_expire) begin
                        n_running[r_idx] = 1'b0;
                        if (r_cnt < otsp_pkg::CNT_W'(otsp_pkg::MAX_RESULTS)) begin
                            n_cnt = r_cnt + 1'b1;
                            // the held report is not the last one: send it on
                            if (r_pend_valid) begin
                                n_out_valid  = 1'b1;
                                n_out_kind   = r_pend_kind;
                                n_out_id     = r_pend_id;
                                n_out_ok     = r_pend_ok;
                                n_out_was    = r_pend_was;
                                n_out_status = r_pend_status;
                                n_out_last   = 1'b0;
                            end
                            n_pend_valid  = 1'b1;
                            n_pend_kind   = otsp_pkg::KIND_EXPIRED;
                            n_pend_id     = SLOT_ID_CAST(r_idx);
                            n_pend_ok     = 1'b1;
                            n_pend_was    = 1'b0;
                            n_pend_status = 1'b0;
                        end
                    end
                    if (w_last_slot) begin
                        n_state = ST_FLUSH;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_idx_inc;
                        n_idx     = w_idx_inc;
                    end
                end
            end
            ST_START: begin
                if (!r_running[r_idx]) begin
                    w_wr_en          = 1'b1;
                    w_wr_data        = r_cmd.period;
                    n_running[r_idx] = 1'b1;
                    n_pend_valid     = 1'b1;
                    n_pend_kind      = otsp_pkg::KIND_START;
                    n_pend_id        = SLOT_ID_CAST(r_idx);
                    n_pend_ok        = 1'b1;
                    n_pend_was       = 1'b0;
                    n_pend_status    = 1'b0;
                    n_state          = ST_FLUSH;
                end else if (w_last_slot) begin
                    n_pend_valid  = 1'b1;
                    n_pend_kind   = otsp_pkg::KIND_START;
                    n_pend_id     = 3'd0;
                    n_pend_ok     = 1'b0;
                    n_pend_was    = 1'b0;
                    n_pend_status = 1'b0;
                    n_state       = ST_FLUSH;
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            default: begin
                if (r_pend_valid) begin
                    if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = r_pend_kind;
                        n_out_id     = r_pend_id;
                        n_out_ok     = r_pend_ok;
                        n_out_was    = r_pend_was;
                        n_out_status = r_pend_status;
                        n_out_last   = 1'b1;
                        n_pend_valid = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_running    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_running    <= n_running;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_pend_kind   <= n_pend_kind;
        r_pend_id     <= n_pend_id;
        r_pend_ok     <= n_pend_ok;
        r_pend_was    <= n_pend_was;
        r_pend_status <= n_pend_status;
        r_out_kind    <= n_out_kind;
        r_out_id      <= n_out_id;
        r_out_ok      <= n_out_ok;
        r_out_was     <= n_out_was;
        r_out_status  <= n_out_status;
        r_out_last    <= n_out_last;
    end

    // remaining-count memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_out_kind;
    assign o_slot_id     = r_out_id;
    assign o_ok          = r_out_ok;
    assign o_was_running = r_out_was;
    assign o_slot_status = r_out_status;
    assign o_last        = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= otsp_pkg::CNT_W'(otsp_pkg::MAX_RESULTS))
        else $error("expiry report count beyond limit");

    a_stall_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |-> (r_pend_valid && r_out_valid && i_out_stall))
        else $error("tick stalled without a held report");

    a_tick_emit_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick_emit |=> (r_out_valid && (r_out_kind == otsp_pkg::KIND_EXPIRED) && !r_out_last))
        else $error("mid-tick expiry report flagged last");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held report left over in idle");

endmodule

>>> sv/one_shot_timer_pool_top.sv
// one_shot_timer_pool_top: top level of the one-shot timer pool
// depends on otsp_pkg, otsp_front, otsp_queue and otsp_back
`timescale 1ns / 1ps

// A pool of TIMER_SLOTS one-shot countdown timers behind a valid/stall input
// and a valid/stall output. A start transaction claims the lowest idle slot
// when its period is a multiple of 10; a tick decrements every running slot
// and reports each slot that hits zero, in slot order, with last set on the
// final report (at most 8 reports per tick, every expired slot still goes
// idle); stop and status address a slot by number. The front classifies each
// transaction and drops it into a two-entry queue; the back sequencer works on
// one command at a time. A tick walks the remaining-count memory one slot per
// cycle through its single registered read port, unless an expiry report has
// to wait on a full, stalled output register; a start scans the running flags
// in slot order, and stop and status need no scan. A full, stalled output
// register also holds back the final report of any command. Reset makes
// all slots idle at once; no clearing pass is needed.

module one_shot_timer_pool_top #(
    parameter int TIMER_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_period,
    input  logic [3:0]  i_timer_select,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_kind,
    output logic [2:0]  o_slot_id,
    output logic        o_ok,
    output logic        o_was_running,
    output logic        o_slot_status,
    output logic        o_last
);

    // front to queue
    logic           w_push;
    logic           w_q_full;
    otsp_pkg::t_cmd w_entry;

    // queue to back
    logic           w_pop;
    logic           w_q_empty;
    otsp_pkg::t_cmd w_head;

    // classify each transaction: period check and slot-number range check
    otsp_front #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_period       (i_period),
        .i_timer_select (i_timer_select),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_entry        (w_entry)
    );

    // lets the front keep accepting while the back works or waits on output
    otsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    // slot state, countdown memory and the registered result stage
    otsp_back #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_head      (w_head),
        .o_q_pop       (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_kind  (o_event_kind),
        .o_slot_id     (o_slot_id),
        .o_ok          (o_ok),
        .o_was_running (o_was_running),
        .o_slot_status (o_slot_status),
        .o_last        (o_last)
    );

endmodule

>>> dv/one_shot_timer_pool_top_tb.sv
// one_shot_timer_pool_top_tb: self-checking testbench of the one-shot timer pool
// drives start, stop, status and tick transactions and checks every result in order
// depends on otsp_pkg and one_shot_timer_pool_top
`timescale 1ns / 1ps

module one_shot_timer_pool_top_tb;

    localparam int          CLK_PERIOD    = 8;
    localparam int          RESET_CYCLES  = 10;
    localparam int          POOL_SLOTS    = 8;
    localparam logic [31:0] PERIOD_STEP   = 32'd10;
    localparam int          RANDOM_ITEMS  = 220;
    // random items that run with no idling on either side
    localparam int          CALM_FIRST    = 100;
    localparam int          CALM_LAST     = 149;
    // random item at which the result side starts its long hold-off
    localparam int          HOLD_ITEM     = 180;
    localparam int          HOLD_CYCLES   = 300;
    // a tick walks every slot, plus margin for stalls at the result side
    localparam int          SETTLE_CYCLES = 4 * POOL_SLOTS + 40;
    localparam int          DRAIN_LIMIT   = 20000;

    // one result transaction, field for field as on the result ports
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] slot;
        logic       ok;
        logic       was_running;
        logic       slot_status;
        logic       last;
    } t_timer_event;

    // timer pool predictor plus the queue of results still owed by the block
    class t_timer_scoreboard;
        bit           running   [POOL_SLOTS];
        logic [31:0]  remaining [POOL_SLOTS];
        t_timer_event pending   [$];
        int           errors;

        function new();
            for (int i = 0; i < POOL_SLOTS; i++) begin
                running[i]   = 1'b0;
                remaining[i] = 32'd0;
            end
            errors = 0;
        endfunction

        // update the pool for one accepted transaction and queue what it must produce
        function void note_command(logic [1:0] cmd, logic [31:0] per, logic [3:0] sel);
            t_timer_event ev;
            t_timer_event fired [POOL_SLOTS];
            int           n;
            int           slot;
            n        = 0;
            slot     = -1;
            ev       = '0;
            ev.last  = 1'b1;
            case (cmd)
                otsp_pkg::CMD_TICK: begin
                    for (int i = 0; i < POOL_SLOTS; i++) begin
                        if (running[i]) begin
                            remaining[i] = remaining[i] - 32'd1;
                            if (remaining[i] == 32'd0) begin
                                // every expired slot goes idle, only the first few are reported
                                running[i] = 1'b0;
                                if (n < otsp_pkg::MAX_RESULTS) begin
                                    fired[n]      = '0;
                                    fired[n].kind = otsp_pkg::KIND_EXPIRED;
                                    fired[n].slot = 3'(i);
                                    fired[n].ok   = 1'b1;
                                    n++;
                                end
                            end
                        end
                    end
                    for (int k = 0; k < n; k++) begin
                        fired[k].last = (k == n - 1);
                        pending.push_back(fired[k]);
                    end
                end
                otsp_pkg::CMD_START: begin
                    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
                        if (!running[i]) slot = i;
                    end
                    ev.kind = otsp_pkg::KIND_START;
                    if (slot >= 0 && (per % PERIOD_STEP) == 32'd0) begin
                        remaining[slot] = per;
                        running[slot]   = 1'b1;
                        ev.slot         = 3'(slot);
                        ev.ok           = 1'b1;
                    end
                    pending.push_back(ev);
                end
                otsp_pkg::CMD_STOP: begin
                    ev.kind = otsp_pkg::KIND_STOP;
                    ev.slot = sel[2:0];
                    if (sel < POOL_SLOTS) begin
                        ev.ok          = 1'b1;
                        ev.was_running = running[sel];
                        running[sel]   = 1'b0;
                    end
                    pending.push_back(ev);
                end
                default: begin
                    ev.kind = otsp_pkg::KIND_STATUS;
                    ev.slot = sel[2:0];
                    if (sel < POOL_SLOTS) begin
                        ev.ok          = 1'b1;
                        ev.slot_status = running[sel];
                    end
                    pending.push_back(ev);
                end
            endcase
        endfunction

        function string describe(t_timer_event ev);
            return $sformatf("kind %0d slot %0d ok %0b was %0b status %0b last %0b",
                             ev.kind, ev.slot, ev.ok, ev.was_running, ev.slot_status, ev.last);
        endfunction

        task report(string msg);
            $display("%0t ns: ERROR %s", $time, msg);
            errors++;
        endtask

        // compare one accepted result with the oldest expectation
        task check_result(t_timer_event got);
            t_timer_event want;
            string        bad;
            if (pending.size() == 0) begin
                report({"result with nothing expected: ", describe(got)});
                return;
            end
            want = pending.pop_front();
            bad  = "";
            if (got.kind !== want.kind) bad = {bad, " event_kind"};
            if (got.slot !== want.slot) bad = {bad, " slot_id"};
            if (got.ok !== want.ok) bad = {bad, " ok"};
            if (got.was_running !== want.was_running) bad = {bad, " was_running"};
            if (got.slot_status !== want.slot_status) bad = {bad, " slot_status"};
            if (got.last !== want.last) bad = {bad, " last"};
            if (bad != "") begin
                report({"wrong", bad, ": expected ", describe(want), ", got ", describe(got)});
            end
        endtask

        task flush_leftovers();
            while (pending.size() != 0) begin
                report({"result never arrived: ", describe(pending.pop_front())});
            end
        endtask
    endclass

    // block ports; the inputs are known from time zero
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_command      = otsp_pkg::CMD_TICK;
    logic [31:0] i_period       = 32'd0;
    logic [3:0]  i_timer_select = 4'd0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [1:0]  o_event_kind;
    logic [2:0]  o_slot_id;
    logic        o_ok;
    logic        o_was_running;
    logic        o_slot_status;
    logic        o_last;

    t_timer_scoreboard sb;

    // traffic shaping shared between the sender and the result side
    bit          calm        = 1'b0;  // no idling on either side
    bit          hold_req    = 1'b0;  // sender asks for the long hold-off
    bit          hold_active = 1'b0;  // result side is in the long hold-off
    int unsigned hold_left   = 0;

    one_shot_timer_pool_top #(
        .TIMER_SLOTS (POOL_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_period       (i_period),
        .i_timer_select (i_timer_select),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_kind   (o_event_kind),
        .o_slot_id      (o_slot_id),
        .o_ok           (o_ok),
        .o_was_running  (o_was_running),
        .o_slot_status  (o_slot_status),
        .o_last         (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // offer one transaction, idling first at random, and note it once the block takes it;
    // signals read right after the edge still hold the values the edge saw
    task automatic send_command(input logic [1:0] cmd, input logic [31:0] per,
                                input logic [3:0] sel);
        if (!calm && !hold_active) begin
            while ($urandom_range(99) < 32) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_period       <= per;
        i_timer_select <= sel;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(cmd, per, sel);
    endtask

    // mostly ticks and well-formed starts with short periods so that timers
    // really expire; zero, huge and malformed periods and bad ids mixed in
    task automatic random_command();
        int unsigned pick;
        logic [1:0]  cmd;
        logic [31:0] per;
        logic [3:0]  sel;
        pick = $urandom_range(99);
        per  = $urandom;
        sel  = ($urandom_range(99) < 85) ? 4'($urandom_range(0, POOL_SLOTS - 1))
                                         : 4'($urandom_range(POOL_SLOTS, 15));
        if (pick < 55) begin
            cmd = otsp_pkg::CMD_TICK;
        end else if (pick < 75) begin
            cmd  = otsp_pkg::CMD_START;
            pick = $urandom_range(99);
            if (pick < 70) begin
                per = PERIOD_STEP * $urandom_range(1, 5);
            end else if (pick < 78) begin
                // zero period wraps and effectively parks the slot until a stop
                per = 32'd0;
            end else if (pick < 86) begin
                per = $urandom;
            end else if (pick < 93) begin
                // just off a multiple of the step, always rejected
                per = PERIOD_STEP * $urandom_range(1, 5) + $urandom_range(1, 9);
            end else begin
                per = ($urandom / PERIOD_STEP) * PERIOD_STEP;
            end
        end else if (pick < 87) begin
            cmd = otsp_pkg::CMD_STOP;
        end else begin
            cmd = otsp_pkg::CMD_STATUS;
        end
        send_command(cmd, per, sel);
    endtask

    // result side: random stalls, none during the calm stretch, and one long hold-off
    // that backs the pool up until the input stalls too
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req    = 1'b0;
            hold_active = 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            hold_active = 1'b0;
            i_out_stall <= !calm && ($urandom_range(99) < 32);
        end
    end

    // every accepted result goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(t_timer_event'({o_event_kind, o_slot_id, o_ok, o_was_running,
                                            o_slot_status, o_last}));
        end
    end

    initial begin
        int drain;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bad ids on status and stop, stop of an idle slot
        send_command(otsp_pkg::CMD_STATUS, 32'd0, 4'd15);
        send_command(otsp_pkg::CMD_STOP, 32'd0, 4'(POOL_SLOTS));
        send_command(otsp_pkg::CMD_STOP, 32'd0, 4'd3);
        // periods off the step are refused, zero and the largest step multiple are taken
        send_command(otsp_pkg::CMD_START, 32'd7, 4'd0);
        send_command(otsp_pkg::CMD_START, 32'hFFFF_FFFF, 4'd0);
        send_command(otsp_pkg::CMD_START, 32'd0, 4'd0);
        send_command(otsp_pkg::CMD_START, 32'hFFFF_FFFA, 4'd0);
        send_command(otsp_pkg::CMD_STATUS, 32'd0, 4'd1);
        // stop running slots
        send_command(otsp_pkg::CMD_STOP, 32'd0, 4'd0);
        send_command(otsp_pkg::CMD_STOP, 32'd0, 4'd1);
        // tick with nothing running gives no result
        send_command(otsp_pkg::CMD_TICK, 32'd0, 4'd0);
        // fill the pool, then one start too many
        for (int k = 0; k < POOL_SLOTS; k++) begin
            send_command(otsp_pkg::CMD_START, PERIOD_STEP, 4'd0);
        end
        send_command(otsp_pkg::CMD_START, PERIOD_STEP, 4'd0);
        // every slot expires on the same tick
        for (int k = 0; k < PERIOD_STEP; k++) begin
            send_command(otsp_pkg::CMD_TICK, 32'd0, 4'd0);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            calm = (k >= CALM_FIRST && k <= CALM_LAST);
            if (k == HOLD_ITEM) hold_req = 1'b1;
            random_command();
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;

        // wait for outstanding results, then give a trailing tick time to finish
        drain = 0;
        while (sb.pending.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.flush_leftovers();

        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #(4_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
